// ===== hw/rtl/morse_pkg.sv =====
// morse keying sequencer package: state encoding, code tables and lookup
// no dependencies; imported by morse_keying_sequencer
package morse_pkg;

  // configuration register indexes
  localparam logic [7:0] CfgDitIdx = 8'd0;
  localparam logic [7:0] CfgDahIdx = 8'd1;

  // register reset values in milliseconds
  localparam logic [15:0] DitReset = 16'd100;
  localparam logic [15:0] DahReset = 16'd300;

  // most elements in one character
  localparam logic [2:0] MaxElems = 3'd5;

  // sequencer states, one-hot
  typedef enum logic [3:0] {
    StIdle  = 4'b0001,
    StTone  = 4'b0010,
    StGap   = 4'b0100,
    StClose = 4'b1000
  } seq_state_e;

  // code byte: element count in [7:5], elements in [4:0], first in bit 4, 1 = dit
  localparam logic [7:0] LetterCodes [26] = '{
    8'h50, 8'h8E, 8'h8A, 8'h6C, 8'h30, 8'h9A, 8'h64, 8'h9E, 8'h58, 8'h90,
    8'h68, 8'h96, 8'h40, 8'h48, 8'h60, 8'h92, 8'h84, 8'h74, 8'h7C, 8'h20,
    8'h78, 8'h9C, 8'h70, 8'h8C, 8'h88, 8'h86
  };

  localparam logic [7:0] DigitCodes [10] = '{
    8'hA0, 8'hB0, 8'hB8, 8'hBC, 8'hBE, 8'hBF, 8'hAF, 8'hA7, 8'hA3, 8'hA1
  };

  // code byte for an ascii character, zero when not encoded
  function automatic logic [7:0] code_for(input logic [7:0] ch);
    logic [7:0] ofs;
    logic [7:0] code;
    code = 8'h00;
    ofs  = 8'h00;
    case (ch) inside
      [8'h41:8'h5A]: begin
        ofs  = ch - 8'h41;
        code = LetterCodes[ofs[4:0]];
      end
      [8'h30:8'h39]: begin
        ofs  = ch - 8'h30;
        code = DigitCodes[ofs[3:0]];
      end
      default: code = 8'h00;
    endcase
    return code;
  endfunction

endpackage

// ===== hw/rtl/morse_keying_sequencer.sv =====
// morse keying sequencer top level: code lookup, element sequencer, output register
// depends on morse_pkg
//
// usage
//   input channel (in_valid_i/in_ready_o) takes one beat per character: an ascii
//   byte and a flag marking the last character of a message. A-Z and 0-9 are
//   keyed, every other byte gives only the closing silence.
//   output channel (out_valid_o/out_ready_i) gives one beat per timed segment:
//   key state, length in ms, end-of-character and end-of-message flags.
//   config channel (cfg_valid_i/cfg_ready_o) writes dit length (index 0) or dah
//   length (index 1); other indexes are dropped. write only while idle.
// timing
//   a character with n elements makes 2n+1 segments. the input beat moves the state
//   register out of idle, and the first segment then enters the output register; the
//   rest follow one per cycle while the receiver does not stall. the single element
//   shift register shifts once per tone and its count steps down once per gap.
//   in_ready_o is low from the input beat until the closing segment is loaded.
// reset and stall
//   reset loads dit 100 and dah 300 and empties the output register. when the
//   receiver stalls, the output register holds its beat and the sequencer waits.
module morse_keying_sequencer
  import morse_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // config write
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  // character in
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  character_i,
  input  logic        final_char_i,
  // segment out
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        key_on_o,
  output logic [15:0] duration_o,
  output logic        char_done_o,
  output logic        message_end_o
);

  seq_state_e  state_q, state_d;
  logic [15:0] dit_q, dah_q;
  logic [4:0]  elem_q, elem_d;
  logic [2:0]  cnt_q, cnt_d;
  logic        last_q, last_d;

  logic        out_valid_q;
  logic        key_on_q, key_on_d;
  logic [15:0] dur_q, dur_d;
  logic        done_q, done_d;
  logic        mend_q, mend_d;

  logic        in_acc;
  logic        load;
  logic        emit;
  logic [7:0]  code;
  logic [2:0]  code_cnt;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == StIdle);
  assign in_acc      = in_valid_i && in_ready_o;
  assign load        = !out_valid_q || out_ready_i;

  // table lookup with element count clamp
  assign code     = code_for(character_i);
  assign code_cnt = (code[7:5] > MaxElems) ? MaxElems : code[7:5];

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dit_q <= DitReset;
      dah_q <= DahReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i == CfgDitIdx) dit_q <= cfg_data_i;
      else if (cfg_index_i == CfgDahIdx) dah_q <= cfg_data_i;
    end
  end

  // element sequencer
  always_comb begin
    state_d  = state_q;
    elem_d   = elem_q;
    cnt_d    = cnt_q;
    last_d   = last_q;
    emit     = 1'b0;
    key_on_d = 1'b0;
    dur_d    = dit_q;
    done_d   = 1'b0;
    mend_d   = 1'b0;
    case (state_q)
      StIdle: begin
        if (in_acc) begin
          elem_d  = code[4:0];
          cnt_d   = code_cnt;
          last_d  = final_char_i;
          state_d = (code_cnt == 3'd0) ? StClose : StTone;
        end
      end
      StTone: begin
        if (load) begin
          emit     = 1'b1;
          key_on_d = 1'b1;
          dur_d    = elem_q[4] ? dit_q : dah_q;
          elem_d   = {elem_q[3:0], 1'b0};
          state_d  = StGap;
        end
      end
      StGap: begin
        if (load) begin
          emit    = 1'b1;
          dur_d   = dit_q;
          cnt_d   = cnt_q - 3'd1;
          state_d = (cnt_q == 3'd1) ? StClose : StTone;
        end
      end
      StClose: begin
        if (load) begin
          emit    = 1'b1;
          dur_d   = dah_q;
          done_d  = 1'b1;
          mend_d  = last_q;
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q   <= 3'd0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    elem_q <= elem_d;
    last_q <= last_d;
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      key_on_q <= key_on_d;
      dur_q    <= dur_d;
      done_q   <= done_d;
      mend_q   <= mend_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign key_on_o      = key_on_q;
  assign duration_o    = dur_q;
  assign char_done_o   = done_q;
  assign message_end_o = mend_q;

  // busy right after a character beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !in_ready_o)
    else $error("sequencer ready right after taking a character");

  // closing segment lands in the output register with its flag
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StClose) && load |=> out_valid_o && char_done_o && !key_on_o)
    else $error("closing silence not presented");

  // message end only on a closing segment
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && message_end_o |-> char_done_o)
    else $error("message end outside closing segment");

  // element count stays within a character
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= MaxElems)
    else $error("element count out of range");

endmodule
